// File: src/rotation_vector_to_matrix_top_defines.svh
// Assertion macros used by the RVM top-level design file.
`ifndef ROTATION_VECTOR_TO_MATRIX_TOP_DEFINES_SVH
`define ROTATION_VECTOR_TO_MATRIX_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define RVM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define RVM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define RVM_ASSERT_IMPL(lbl, ante, cons, msg)
`define RVM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: src/rvm_pkg.sv
`default_nettype none
package rvm_pkg;

  localparam int TRIG_ITERATIONS = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int CORDIC_STEPS =
    (TRIG_ITERATIONS < ATAN_ENTRIES) ? TRIG_ITERATIONS : ATAN_ENTRIES;
  localparam int SQRT_STEPS = 19;
  localparam int DIV_STEPS = 56;

  localparam logic signed [36:0] Q30_PI = 37'sd3373259426;
  localparam logic signed [36:0] Q30_TWO_PI = 37'sd6746518852;
  localparam logic signed [36:0] Q30_HALF_PI = 37'sd1686629713;
  localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
  localparam logic [17:0] SMALL_NORM = 18'd1024;
  localparam logic signed [15:0] SAT_POS = 16'sd16384;
  localparam logic signed [15:0] SAT_NEG = -16'sd16384;

  typedef struct packed {
    logic signed [15:0] rot_x;
    logic signed [15:0] rot_y;
    logic signed [15:0] rot_z;
  } rvm_in_t;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
  } rvm_out_t;

  typedef struct packed {
    logic signed [15:0] wx;
    logic signed [15:0] wy;
    logic signed [15:0] wz;
    logic [31:0]        s;
  } rvm_side_t;

  function automatic logic [29:0] atan_q30(input int idx);
    logic [29:0] v;
    unique case (idx)
      0:  v = 30'd843314856;
      1:  v = 30'd497837829;
      2:  v = 30'd263043836;
      3:  v = 30'd133525158;
      4:  v = 30'd67021686;
      5:  v = 30'd33543515;
      6:  v = 30'd16775850;
      7:  v = 30'd8388437;
      8:  v = 30'd4194282;
      9:  v = 30'd2097149;
      10: v = 30'd1048575;
      11: v = 30'd524287;
      12: v = 30'd262143;
      13: v = 30'd131071;
      14: v = 30'd65535;
      15: v = 30'd32767;
      16: v = 30'd16383;
      17: v = 30'd8191;
      18: v = 30'd4095;
      19: v = 30'd2047;
      20: v = 30'd1023;
      21: v = 30'd511;
      22: v = 30'd255;
      23: v = 30'd127;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// File: src/rvm_norm.sv
`default_nettype none
module rvm_norm (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  rvm_pkg::rvm_in_t  in_data,
  output logic              out_valid,
  output rvm_pkg::rvm_side_t out_side,
  output logic [17:0]       out_r
);
  import rvm_pkg::*;

  logic               w_valid_r;
  logic signed [15:0] wx_r, wy_r, wz_r;
  logic signed [31:0] px, py, pz;
  logic [31:0]        sum;

  logic [SQRT_STEPS:0] v_r;
  rvm_side_t           side_r [SQRT_STEPS+1];
  logic [37:0]         rem_r  [SQRT_STEPS+1];
  logic [37:0]         res_r  [SQRT_STEPS+1];
  logic [37:0]         trial  [SQRT_STEPS];
  logic [37:0]         rem_nxt [SQRT_STEPS];
  logic [37:0]         res_nxt [SQRT_STEPS];

  always_comb begin
    px = wx_r * wx_r;
    py = wy_r * wy_r;
    pz = wz_r * wz_r;
    sum = 32'(px) + 32'(py) + 32'(pz);
  end

  always_comb begin
    for (int k = 0; k < SQRT_STEPS; k++) begin
      trial[k] = res_r[k] + (38'd1 << (36 - 2 * k));
      if (rem_r[k] >= trial[k]) begin
        rem_nxt[k] = rem_r[k] - trial[k];
        res_nxt[k] = (res_r[k] >> 1) + (38'd1 << (36 - 2 * k));
      end else begin
        rem_nxt[k] = rem_r[k];
        res_nxt[k] = res_r[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_valid_r <= 1'b0;
      v_r <= '0;
    end else if (en) begin
      w_valid_r <= in_valid;
      v_r <= {v_r[SQRT_STEPS-1:0], w_valid_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wx_r <= in_data.rot_x;
      wy_r <= in_data.rot_y;
      wz_r <= in_data.rot_z;
      side_r[0] <= '{wx: wx_r, wy: wy_r, wz: wz_r, s: sum};
      rem_r[0] <= {2'b00, sum, 4'b0000};
      res_r[0] <= '0;
      for (int k = 0; k < SQRT_STEPS; k++) begin
        side_r[k+1] <= side_r[k];
        rem_r[k+1] <= rem_nxt[k];
        res_r[k+1] <= res_nxt[k];
      end
    end
  end

  assign out_valid = v_r[SQRT_STEPS];
  assign out_side = side_r[SQRT_STEPS];
  assign out_r = res_r[SQRT_STEPS][17:0];
endmodule
`default_nettype wire

// File: src/rvm_cordic.sv
`default_nettype none
module rvm_cordic (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  rvm_pkg::rvm_side_t in_side,
  input  logic [17:0]        in_r,
  output logic               out_valid,
  output rvm_pkg::rvm_side_t out_side,
  output logic [17:0]        out_r,
  output logic signed [32:0] out_sin,
  output logic signed [32:0] out_cos
);
  import rvm_pkg::*;

  logic signed [36:0] th0, th1, th2;
  logic               red_valid_r;
  logic signed [36:0] th_r;
  rvm_side_t          red_side_r;
  logic [17:0]        red_r_r;
  logic signed [36:0] fold;
  logic               fold_neg;

  logic [CORDIC_STEPS:0] v_r;
  logic signed [32:0]    x_r [CORDIC_STEPS+1];
  logic signed [32:0]    y_r [CORDIC_STEPS+1];
  logic signed [32:0]    z_r [CORDIC_STEPS+1];
  logic                  neg_r [CORDIC_STEPS+1];
  rvm_side_t             side_r [CORDIC_STEPS+1];
  logic [17:0]           r_r [CORDIC_STEPS+1];
  logic signed [32:0]    x_nxt [CORDIC_STEPS];
  logic signed [32:0]    y_nxt [CORDIC_STEPS];
  logic signed [32:0]    z_nxt [CORDIC_STEPS];

  logic               fin_valid_r;
  logic signed [32:0] sin_r, cos_r;
  rvm_side_t          fin_side_r;
  logic [17:0]        fin_r_r;

  always_comb begin
    th0 = $signed({3'b000, in_r, 16'h0000});
    th1 = (th0 > Q30_PI) ? th0 - Q30_TWO_PI : th0;
    th2 = (th1 > Q30_PI) ? th1 - Q30_TWO_PI : th1;
  end

  always_comb begin
    priority if (th_r > Q30_HALF_PI) begin
      fold = Q30_PI - th_r;
      fold_neg = 1'b1;
    end else if (th_r < -Q30_HALF_PI) begin
      fold = -Q30_PI - th_r;
      fold_neg = 1'b1;
    end else begin
      fold = th_r;
      fold_neg = 1'b0;
    end
  end

  always_comb begin
    for (int k = 0; k < CORDIC_STEPS; k++) begin
      if (z_r[k] >= 0) begin
        x_nxt[k] = x_r[k] - (y_r[k] >>> k);
        y_nxt[k] = y_r[k] + (x_r[k] >>> k);
        z_nxt[k] = z_r[k] - $signed({3'b000, atan_q30(k)});
      end else begin
        x_nxt[k] = x_r[k] + (y_r[k] >>> k);
        y_nxt[k] = y_r[k] - (x_r[k] >>> k);
        z_nxt[k] = z_r[k] + $signed({3'b000, atan_q30(k)});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_valid_r <= 1'b0;
      v_r <= '0;
      fin_valid_r <= 1'b0;
    end else if (en) begin
      red_valid_r <= in_valid;
      v_r <= {v_r[CORDIC_STEPS-1:0], red_valid_r};
      fin_valid_r <= v_r[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      th_r <= th2;
      red_side_r <= in_side;
      red_r_r <= in_r;
      x_r[0] <= CORDIC_GAIN;
      y_r[0] <= '0;
      z_r[0] <= 33'(fold);
      neg_r[0] <= fold_neg;
      side_r[0] <= red_side_r;
      r_r[0] <= red_r_r;
      for (int k = 0; k < CORDIC_STEPS; k++) begin
        x_r[k+1] <= x_nxt[k];
        y_r[k+1] <= y_nxt[k];
        z_r[k+1] <= z_nxt[k];
        neg_r[k+1] <= neg_r[k];
        side_r[k+1] <= side_r[k];
        r_r[k+1] <= r_r[k];
      end
      sin_r <= y_r[CORDIC_STEPS];
      cos_r <= neg_r[CORDIC_STEPS] ? -x_r[CORDIC_STEPS] : x_r[CORDIC_STEPS];
      fin_side_r <= side_r[CORDIC_STEPS];
      fin_r_r <= r_r[CORDIC_STEPS];
    end
  end

  assign out_valid = fin_valid_r;
  assign out_side = fin_side_r;
  assign out_r = fin_r_r;
  assign out_sin = sin_r;
  assign out_cos = cos_r;
endmodule
`default_nettype wire

// File: src/rvm_div.sv
`default_nettype none
module rvm_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  rvm_pkg::rvm_side_t in_side,
  input  logic [17:0]        in_r,
  input  logic signed [32:0] in_sin,
  input  logic signed [32:0] in_cos,
  output logic               out_valid,
  output rvm_pkg::rvm_side_t out_side,
  output logic signed [36:0] out_a,
  output logic signed [40:0] out_b
);
  import rvm_pkg::*;

  logic               is_small;
  logic signed [33:0] tb;
  logic [32:0]        mag_s;
  logic [33:0]        mag_b;
  logic [55:0]        num_a0, num_b0;
  logic [31:0]        den_a0, den_b0;

  logic [DIV_STEPS:0] v_r;
  logic [55:0]        na_r [DIV_STEPS+1];
  logic [55:0]        nb_r [DIV_STEPS+1];
  logic [31:0]        ra_r [DIV_STEPS+1];
  logic [31:0]        rb_r [DIV_STEPS+1];
  logic [31:0]        da_r [DIV_STEPS+1];
  logic [31:0]        db_r [DIV_STEPS+1];
  logic               small_r [DIV_STEPS+1];
  logic               nega_r [DIV_STEPS+1];
  logic               negb_r [DIV_STEPS+1];
  rvm_side_t          side_r [DIV_STEPS+1];

  logic [32:0] rema2 [DIV_STEPS];
  logic [32:0] remb2 [DIV_STEPS];
  logic        gea [DIV_STEPS];
  logic        geb [DIV_STEPS];

  logic signed [36:0] qa;
  logic signed [40:0] qb;
  logic               fin_valid_r;
  logic signed [36:0] a_r;
  logic signed [40:0] b_r;
  rvm_side_t          fin_side_r;

  always_comb begin
    is_small = in_r < SMALL_NORM;
    tb = 34'sd1073741824 - 34'(in_cos);
    mag_s = in_sin[32] ? 33'(-in_sin) : 33'(in_sin);
    mag_b = tb[33] ? 34'(-tb) : 34'(tb);
    if (is_small) begin
      num_a0 = {18'd0, in_side.s, 6'd0};
      num_b0 = {18'd0, in_side.s, 6'd0};
      den_a0 = 32'd6;
      den_b0 = 32'd24;
    end else begin
      num_a0 = {9'd0, mag_s, 14'd0};
      num_b0 = {mag_b[31:0], 24'd0};
      den_a0 = {14'd0, in_r};
      den_b0 = in_side.s;
    end
  end

  always_comb begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      rema2[k] = {ra_r[k], na_r[k][55]};
      remb2[k] = {rb_r[k], nb_r[k][55]};
      gea[k] = rema2[k] >= {1'b0, da_r[k]};
      geb[k] = remb2[k] >= {1'b0, db_r[k]};
    end
  end

  always_comb begin
    qa = $signed(na_r[DIV_STEPS][36:0]);
    qb = $signed(nb_r[DIV_STEPS][40:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
      fin_valid_r <= 1'b0;
    end else if (en) begin
      v_r <= {v_r[DIV_STEPS-1:0], in_valid};
      fin_valid_r <= v_r[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      na_r[0] <= num_a0;
      nb_r[0] <= num_b0;
      ra_r[0] <= '0;
      rb_r[0] <= '0;
      da_r[0] <= den_a0;
      db_r[0] <= den_b0;
      small_r[0] <= is_small;
      nega_r[0] <= in_sin[32];
      negb_r[0] <= tb[33];
      side_r[0] <= in_side;
      for (int k = 0; k < DIV_STEPS; k++) begin
        na_r[k+1] <= {na_r[k][54:0], gea[k]};
        nb_r[k+1] <= {nb_r[k][54:0], geb[k]};
        ra_r[k+1] <= gea[k] ? 32'(rema2[k] - {1'b0, da_r[k]}) : rema2[k][31:0];
        rb_r[k+1] <= geb[k] ? 32'(remb2[k] - {1'b0, db_r[k]}) : remb2[k][31:0];
        da_r[k+1] <= da_r[k];
        db_r[k+1] <= db_r[k];
        small_r[k+1] <= small_r[k];
        nega_r[k+1] <= nega_r[k];
        negb_r[k+1] <= negb_r[k];
        side_r[k+1] <= side_r[k];
      end
      if (small_r[DIV_STEPS]) begin
        a_r <= 37'sd1073741824 - qa;
        b_r <= 41'sd536870912 - qb;
      end else begin
        a_r <= nega_r[DIV_STEPS] ? -qa : qa;
        b_r <= negb_r[DIV_STEPS] ? -qb : qb;
      end
      fin_side_r <= side_r[DIV_STEPS];
    end
  end

  assign out_valid = fin_valid_r;
  assign out_side = fin_side_r;
  assign out_a = a_r;
  assign out_b = b_r;
endmodule
`default_nettype wire

// File: src/rvm_asm.sv
`default_nettype none
module rvm_asm (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  rvm_pkg::rvm_side_t in_side,
  input  logic signed [36:0] in_a,
  input  logic signed [40:0] in_b,
  output logic               out_valid,
  output rvm_pkg::rvm_out_t  out_data
);
  import rvm_pkg::*;

  localparam logic signed [79:0] ONE_Q54 = 80'sd1 <<< 54;
  localparam logic signed [79:0] ROUND_HALF = 80'sd1 <<< 39;

  function automatic logic signed [15:0] w_of(input int idx, input rvm_side_t sd);
    logic signed [15:0] v;
    unique case (idx)
      0: v = sd.wx;
      1: v = sd.wy;
      default: v = sd.wz;
    endcase
    return v;
  endfunction

  function automatic logic signed [16:0] cm_of(input int e, input rvm_side_t sd);
    logic signed [16:0] v;
    unique case (e)
      1: v = -17'(sd.wz);
      2: v = 17'(sd.wy);
      3: v = 17'(sd.wz);
      5: v = -17'(sd.wx);
      6: v = -17'(sd.wy);
      7: v = 17'(sd.wx);
      default: v = '0;
    endcase
    return v;
  endfunction

  logic [3:0] v_r;

  logic signed [31:0] prod [9];
  logic signed [33:0] sq_nxt [9];
  logic signed [33:0] s34;

  logic signed [33:0] sq_r [9];
  logic signed [16:0] cm_r [9];
  logic signed [36:0] a1_r;
  logic signed [40:0] b1_r;

  logic signed [35:0] pal_r [9];
  logic signed [35:0] pah_r [9];
  logic signed [54:0] pbl_r [9];
  logic signed [54:0] pbh_r [9];

  logic signed [79:0] pa_r [9];
  logic signed [79:0] pb_r [9];

  logic signed [79:0] acc [9];
  logic signed [39:0] vq [9];
  logic [8:0][15:0]   ent;
  rvm_out_t           out_r;

  always_comb begin
    s34 = $signed({2'b00, in_side.s});
    for (int e = 0; e < 9; e++) begin
      prod[e] = w_of(e / 3, in_side) * w_of(e % 3, in_side);
      sq_nxt[e] = (e / 3 == e % 3) ? 34'(prod[e]) - s34 : 34'(prod[e]);
    end
  end

  always_comb begin
    for (int e = 0; e < 9; e++) begin
      acc[e] = pb_r[e] + (pa_r[e] <<< 12) + ROUND_HALF
             + ((e / 3 == e % 3) ? ONE_Q54 : 80'sd0);
      vq[e] = acc[e][79:40];
      priority if (vq[e] > 40'(SAT_POS)) begin
        ent[8-e] = SAT_POS;
      end else if (vq[e] < 40'(SAT_NEG)) begin
        ent[8-e] = SAT_NEG;
      end else begin
        ent[8-e] = vq[e][15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r <= in_a;
      b1_r <= in_b;
      for (int e = 0; e < 9; e++) begin
        sq_r[e] <= sq_nxt[e];
        cm_r[e] <= cm_of(e, in_side);
        pal_r[e] <= $signed({1'b0, a1_r[17:0]}) * cm_r[e];
        pah_r[e] <= $signed(a1_r[36:18]) * cm_r[e];
        pbl_r[e] <= $signed({1'b0, b1_r[19:0]}) * sq_r[e];
        pbh_r[e] <= $signed(b1_r[40:20]) * sq_r[e];
        pa_r[e] <= (80'(pah_r[e]) <<< 18) + 80'(pal_r[e]);
        pb_r[e] <= (80'(pbh_r[e]) <<< 20) + 80'(pbl_r[e]);
      end
      out_r <= rvm_out_t'(ent);
    end
  end

  assign out_valid = v_r[3];
  assign out_data = out_r;
endmodule
`default_nettype wire

// File: src/rotation_vector_to_matrix_top.sv
// Rotation vector (Q3.12) to 3x3 rotation matrix (Q1.14), Rodrigues form.
// Datapath: the 19-step square root, the 16-step CORDIC and the 56-step
// restoring dividers.
// Throughput: one transfer per cycle; a stalled result freezes every stage.
// Reset: synchronous active-low rst_n clears all valid bits.
`default_nettype none
`include "rotation_vector_to_matrix_top_defines.svh"
module rotation_vector_to_matrix_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  rvm_pkg::rvm_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output rvm_pkg::rvm_out_t out_data
);
  import rvm_pkg::*;

  logic               en;
  logic               n_valid, c_valid, d_valid;
  rvm_side_t          n_side, c_side, d_side;
  logic [17:0]        n_r, c_r;
  logic signed [32:0] c_sin, c_cos;
  logic signed [36:0] d_a;
  logic signed [40:0] d_b;

  assign en = !(out_valid && out_stall);
  assign in_stall = out_valid && out_stall;

  rvm_norm u_norm (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(in_valid), .in_data(in_data),
    .out_valid(n_valid), .out_side(n_side), .out_r(n_r)
  );

  rvm_cordic u_cordic (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(n_valid), .in_side(n_side), .in_r(n_r),
    .out_valid(c_valid), .out_side(c_side), .out_r(c_r),
    .out_sin(c_sin), .out_cos(c_cos)
  );

  rvm_div u_div (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(c_valid), .in_side(c_side), .in_r(c_r),
    .in_sin(c_sin), .in_cos(c_cos),
    .out_valid(d_valid), .out_side(d_side), .out_a(d_a), .out_b(d_b)
  );

  rvm_asm u_asm (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(d_valid), .in_side(d_side), .in_a(d_a), .in_b(d_b),
    .out_valid(out_valid), .out_data(out_data)
  );

  `RVM_ASSERT_IMPL(a_stall_needs_result, in_stall, out_valid, "input stalled with no result waiting")
  `RVM_ASSERT_IMPL(a_m00_range, out_valid, ($signed(out_data.m00) <= 16'sd16384) && ($signed(out_data.m00) >= -16'sd16384), "m00 out of range")
  `RVM_ASSERT_IMPL(a_m11_range, out_valid, ($signed(out_data.m11) <= 16'sd16384) && ($signed(out_data.m11) >= -16'sd16384), "m11 out of range")
endmodule
`default_nettype wire
